>>> sv/deq_pkg.sv
`timescale 1ns / 1ps

package deq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int ACT_W  = 3;

    // action codes on the command port; codes above ACT_POP_REAR are no-ops
    typedef enum logic [ACT_W-1:0] {
        ACT_NONE       = 3'd0,
        ACT_PUSH_FRONT = 3'd1,
        ACT_PUSH_REAR  = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_POP_REAR   = 3'd4
    } action_t;

    // operation broadcast to every cell of the row
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_SHIFT_IN,    // push front: every cell takes its left neighbour
        OP_SHIFT_OUT,   // pop front: every cell takes its right neighbour
        OP_APPEND,      // push rear: first empty cell loads the value
        OP_DROP_LAST    // pop rear: last occupied cell empties
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [DATA_W-1:0]   value;
    } cell_ctrl_t;

endpackage

>>> sv/double_ended_queue.sv
`timescale 1ns / 1ps

// Double-ended queue of up to DEPTH signed 32-bit values, built as a row of
// cells with the front element always in the first cell. A command is taken
// on any cycle with start high (busy never rises), so one command per cycle
// is sustained; each command gives exactly one result beat, marked by done,
// in the following cycle, and the receiver cannot hold it off. Pushes move
// the whole row by one cell or fill the first free cell, pops shift the row
// or free the last occupied cell. front_value and rear_value read 0 when
// the queue is empty; a push into a full queue is dropped and flagged with
// rejected, a pop on empty is ignored.
module double_ended_queue (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [deq_pkg::ACT_W-1:0]           action,
    input  logic signed [deq_pkg::DATA_W-1:0]   value,
    output logic                                done,
    output logic signed [deq_pkg::DATA_W-1:0]   front_value,
    output logic signed [deq_pkg::DATA_W-1:0]   rear_value,
    output logic                                is_empty,
    output logic                                is_full,
    output logic                                rejected
);
    import deq_pkg::*;

    logic              accept;
    cell_ctrl_t        ctrl;
    logic              reject_next;
    logic              done_reg;
    logic              rejected_reg;
    logic [DEPTH-1:0]  occ;
    logic [DEPTH-1:0]  last_vec;
    logic [DATA_W-1:0] data [DEPTH];
    logic [DATA_W-1:0] rear_mux;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        ctrl.op     = OP_HOLD;
        ctrl.value  = value;
        reject_next = 1'b0;
        if (accept)
        begin
            unique case (action_t'(action))
                ACT_PUSH_FRONT:
                begin
                    if (occ[DEPTH-1])
                        reject_next = 1'b1;
                    else
                        ctrl.op = OP_SHIFT_IN;
                end
                ACT_PUSH_REAR:
                begin
                    if (occ[DEPTH-1])
                        reject_next = 1'b1;
                    else
                        ctrl.op = OP_APPEND;
                end
                ACT_POP_FRONT: ctrl.op = OP_SHIFT_OUT;
                ACT_POP_REAR:  ctrl.op = OP_DROP_LAST;
                default:       ctrl.op = OP_HOLD;
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic              l_occ;
            logic [DATA_W-1:0] l_data;
            logic              r_occ;
            logic [DATA_W-1:0] r_data;

            if (g == 0)
            begin : g_first
                assign l_occ  = 1'b1;
                assign l_data = value;
            end
            else
            begin : g_mid_l
                assign l_occ  = occ[g-1];
                assign l_data = data[g-1];
            end

            if (g == DEPTH-1)
            begin : g_last
                assign r_occ  = 1'b0;
                assign r_data = '0;
            end
            else
            begin : g_mid_r
                assign r_occ  = occ[g+1];
                assign r_data = data[g+1];
            end

            deq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .left_occ   (l_occ),
                .left_data  (l_data),
                .right_occ  (r_occ),
                .right_data (r_data),
                .occ        (occ[g]),
                .data       (data[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg     <= 1'b0;
            rejected_reg <= 1'b0;
        end
        else
        begin
            done_reg     <= accept;
            rejected_reg <= reject_next;
        end
    end

    // occupancy is a thermometer code, so the rear is the single 1-to-0 step
    assign last_vec = occ & ~{1'b0, occ[DEPTH-1:1]};

    always_comb
    begin
        rear_mux = '0;
        for (int i = 0; i < DEPTH; i++)
            rear_mux = rear_mux | (data[i] & {DATA_W{last_vec[i]}});
    end

    assign done        = done_reg;
    assign front_value = occ[0] ? data[0] : '0;
    assign rear_value  = rear_mux;
    assign is_empty    = !occ[0];
    assign is_full     = occ[DEPTH-1];
    assign rejected    = rejected_reg;

    a_thermometer: assert property (@(posedge clk) disable iff (!rst_n)
        (occ[DEPTH-1:1] & ~occ[DEPTH-2:0]) == '0)
        else $error("occupancy bits not contiguous");

    a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done == $past(accept))
        else $error("result beat does not follow command");

    a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
        rejected |-> (done && is_full))
        else $error("reject without full queue");

    a_reject_push: assert property (@(posedge clk) disable iff (!rst_n)
        reject_next |=> (is_full && $stable(occ)))
        else $error("rejected push changed the queue");

    a_rear_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(last_vec) && (is_empty == (last_vec == '0)))
        else $error("rear position ambiguous");

endmodule

>>> sv/deq_cell.sv
`timescale 1ns / 1ps

module deq_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  deq_pkg::cell_ctrl_t           ctrl,
    input  logic                          left_occ,
    input  logic [deq_pkg::DATA_W-1:0]    left_data,
    input  logic                          right_occ,
    input  logic [deq_pkg::DATA_W-1:0]    right_data,
    output logic                          occ,
    output logic [deq_pkg::DATA_W-1:0]    data
);
    import deq_pkg::*;

    logic              occ_reg;
    logic              occ_next;
    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        occ_next  = occ_reg;
        data_next = data_reg;
        unique case (ctrl.op)
            OP_SHIFT_IN:
            begin
                occ_next  = left_occ;
                data_next = left_data;
            end
            OP_SHIFT_OUT:
            begin
                occ_next  = right_occ;
                data_next = right_data;
            end
            OP_APPEND:
            begin
                // boundary between filled and empty cells
                if (!occ_reg && left_occ)
                begin
                    occ_next  = 1'b1;
                    data_next = ctrl.value;
                end
            end
            OP_DROP_LAST:
            begin
                if (occ_reg && !right_occ)
                    occ_next = 1'b0;
            end
            default:
            begin
                occ_next  = occ_reg;
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= 1'b0;
        else
            occ_reg <= occ_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign occ  = occ_reg;
    assign data = data_reg;

endmodule

>>> tb/tb_double_ended_queue.sv
`timescale 1ns / 1ps

module tb_double_ended_queue;

    import deq_pkg::*;

    localparam int RANDOM_ITEMS = 1125;
    localparam int STALL_LIMIT  = 2000;
    localparam int REPORT_MAX   = 10;

    typedef enum int {
        MODE_GROW,
        MODE_SHRINK,
        MODE_CHURN
    } traffic_mode_t;

    // Ring-buffer view of the deque; one expected beat per accepted command.
    class deque_scoreboard;
        logic [DATA_W-1:0] ring [DEPTH];
        int unsigned       head_slot;
        int unsigned       tail_slot;
        int unsigned       count;
        logic [DATA_W-1:0] exp_front_q [$];
        logic [DATA_W-1:0] exp_rear_q [$];
        logic [2:0]        exp_flags_q [$];   // {is_empty, is_full, rejected}
        int unsigned       errors;
        int unsigned       commands;
        int unsigned       beats_checked;
        int unsigned       pushes_dropped;
        int unsigned       empty_pops;
        int unsigned       full_hits;

        function new();
            head_slot      = 0;
            tail_slot      = 0;
            count          = 0;
            errors         = 0;
            commands       = 0;
            beats_checked  = 0;
            pushes_dropped = 0;
            empty_pops     = 0;
            full_hits      = 0;
        endfunction

        function int unsigned pending();
            return exp_front_q.size();
        endfunction

        function void note_command(logic [ACT_W-1:0] act, logic [DATA_W-1:0] val);
            logic rej;
            rej = 1'b0;
            commands++;
            case (act)
                ACT_PUSH_FRONT:
                    if (count == DEPTH) rej = 1'b1;
                    else
                    begin
                        head_slot       = (head_slot == 0) ? DEPTH - 1 : head_slot - 1;
                        ring[head_slot] = val;
                        count++;
                    end
                ACT_PUSH_REAR:
                    if (count == DEPTH) rej = 1'b1;
                    else
                    begin
                        ring[tail_slot] = val;
                        tail_slot       = (tail_slot + 1) % DEPTH;
                        count++;
                    end
                ACT_POP_FRONT:
                    if (count == 0) empty_pops++;
                    else
                    begin
                        head_slot = (head_slot + 1) % DEPTH;
                        count--;
                    end
                ACT_POP_REAR:
                    if (count == 0) empty_pops++;
                    else
                    begin
                        tail_slot = (tail_slot == 0) ? DEPTH - 1 : tail_slot - 1;
                        count--;
                    end
                default: ;
            endcase
            if (rej) pushes_dropped++;
            if (count == DEPTH) full_hits++;
            exp_front_q.push_back((count != 0) ? ring[head_slot] : '0);
            exp_rear_q.push_back((count != 0) ? ring[(tail_slot + DEPTH - 1) % DEPTH] : '0);
            exp_flags_q.push_back({count == 0, count == DEPTH, rej});
        endfunction

        function void check_result(logic [DATA_W-1:0] front, logic [DATA_W-1:0] rear,
                                   logic empty, logic full, logic rej);
            logic [DATA_W-1:0] e_front;
            logic [DATA_W-1:0] e_rear;
            logic [2:0]        e_flags;
            if (exp_front_q.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected result beat: front %h rear %h ",
                             front, rear, "empty %b full %b rej %b", empty, full, rej);
                return;
            end
            e_front = exp_front_q[0];
            e_rear  = exp_rear_q[0];
            e_flags = exp_flags_q[0];
            exp_front_q.delete(0);
            exp_rear_q.delete(0);
            exp_flags_q.delete(0);
            beats_checked++;
            if (front !== e_front || rear !== e_rear || empty !== e_flags[2]
                || full !== e_flags[1] || rej !== e_flags[0])
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("beat %0d mismatch: front %h/%h rear %h/%h ",
                             beats_checked, e_front, front, e_rear, rear,
                             "empty %b/%b full %b/%b rej %b/%b (exp/got)",
                             e_flags[2], empty, e_flags[1], full, e_flags[0], rej);
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [ACT_W-1:0]         action;
    logic signed [DATA_W-1:0] value;
    logic                     done;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;
    logic                     rejected;

    deque_scoreboard sb = new();

    int unsigned   idle_cycles;
    int unsigned   work_items;
    int unsigned   burst_len;
    int unsigned   mode_left;
    traffic_mode_t mode;
    logic [ACT_W-1:0] next_act;

    double_ended_queue i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .value       (value),
        .done        (done),
        .front_value (front_value),
        .rear_value  (rear_value),
        .is_empty    (is_empty),
        .is_full     (is_full),
        .rejected    (rejected)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Expected beats are noted before the check so a same-edge result still lines up.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_command(action, value);
            if (done)
                sb.check_result(front_value, rear_value, is_empty, is_full, rejected);
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles, %0d results outstanding",
                         idle_cycles, sb.pending());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic issue(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] val);
        start  <= 1'b1;
        action <= act;
        value  <= val;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic pause(input int unsigned cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    function automatic logic [ACT_W-1:0] pick_value_dummy();
        return ACT_NONE;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [ACT_W-1:0] pick_action(traffic_mode_t m);
        int unsigned push_pct;
        push_pct = (m == MODE_GROW) ? 80 : (m == MODE_SHRINK) ? 20 : 50;
        if ($urandom_range(0, 99) < 4)
            return $urandom_range(0, 1) ? ACT_NONE
                 : ACT_W'(int'(ACT_POP_REAR) + int'($urandom_range(1, 3)));
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
        return $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_REAR;
    endfunction

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        action      = ACT_NONE;
        value       = '0;
        idle_cycles = 0;
        work_items  = 0;
        mode_left   = 0;
        mode        = MODE_CHURN;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: pops on empty, rear push into empty, fill to full, drops, spare codes
        issue(ACT_POP_FRONT, 32'h1234_5678);
        issue(ACT_POP_REAR, 32'h8765_4321);
        issue(ACT_NONE, '1);
        issue(ACT_PUSH_REAR, 32'h7fff_ffff);
        issue(ACT_PUSH_FRONT, 32'h8000_0000);
        for (int i = 2; i < DEPTH; i++)
            issue((i % 2) ? ACT_PUSH_REAR : ACT_PUSH_FRONT, (i == 2) ? '1 : (i == 3) ? '0 : i);
        issue(ACT_PUSH_FRONT, 32'hdead_beef);
        issue(ACT_PUSH_REAR, 32'hcafe_f00d);
        issue(ACT_W'(int'(ACT_POP_REAR) + 1), '1);
        issue(ACT_W'(int'(ACT_POP_REAR) + 2), 32'h5555_5555);
        issue(ACT_W'(int'(ACT_POP_REAR) + 3), 32'haaaa_aaaa);
        issue(ACT_POP_FRONT, '0);
        issue(ACT_POP_REAR, '0);
        pause(2);

        // random bursts; traffic mode drifts so the queue swings between empty and full
        while (work_items < RANDOM_ITEMS)
        begin
            burst_len = $urandom_range(1, 24);
            repeat (burst_len)
            begin
                if (mode_left == 0)
                begin
                    mode      = traffic_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(20, 60);
                end
                mode_left--;
                next_act = pick_action(mode);
                work_items++;
                issue(next_act, pick_value());
            end
            if ($urandom_range(0, 3) != 0)
                pause($urandom_range(1, 6));
        end
        start <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);

        $display("%0d commands checked over %0d result beats", sb.commands, sb.beats_checked);
        $display("queue full %0d times, %0d pushes dropped, %0d pops on empty, %0d errors",
                 sb.full_hits, sb.pushes_dropped, sb.empty_pops, sb.errors);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
